// ----- hdl/sfpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpsd_pkg
// Shared types and constants of the SYN flood and port scan detector.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpsd_pkg;

    localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

    localparam logic [15:0] SYN_THR_RST   = 16'd100;
    localparam logic [15:0] SCAN_THR_RST  = 16'd20;
    localparam logic [15:0] FLOOD_THR_RST = 16'd5;
    localparam logic [15:0] WINDOW_RST    = 16'd10;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_SYN_THR   = 2'd0,
        CFG_SCAN_THR  = 2'd1,
        CFG_FLOOD_THR = 2'd2,
        CFG_WINDOW    = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        THREAT_NONE = 2'd0,
        THREAT_SYN  = 2'd1,
        THREAT_SCAN = 2'd2
    } t_threat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HMUL,
        S_HLD,
        S_HMOD,
        S_PST,
        S_PRD,
        S_PCHK,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_PKT_ADD,
        OP_SYN_ADD,
        OP_SYN_GET,
        OP_PAIR,
        OP_PORT_ADD,
        OP_PORT_GET
    } t_op;

    typedef struct packed {
        logic accept;
        logic emit_zero;
        logic win_clr;
        logic sweep;
        logic mul;
        logic hld;
        logic hstep;
        logic hpair;
        logic prb_start;
        logic prb_chk;
        logic emit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic src_ok;
        logic win_exp;
        logic sweep_last;
        logic mod_last;
        logic resolve;
        logic slot_free;
        logic syn_step;
        logic res_syn_hit;
    } t_stat;

endpackage

`default_nettype wire

// ----- hdl/sfpsd_ram.sv -----
// ----------------------------------------------------------------------------
// sfpsd_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/sfpsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfpsd_ctrl
// Sequencer: table clear sweep, two hash passes, then one probe per table op.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpsd_ctrl import sfpsd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_st,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_pend, n_pend;
    logic   r_hpass, n_hpass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_op    <= OP_PKT_ADD;
            r_pend  <= 1'b0;
            r_hpass <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_pend  <= n_pend;
            r_hpass <= n_hpass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_pend  = r_pend;
        n_hpass = r_hpass;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        o_cmd.hpair = r_hpass;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = r_pend ? S_HMUL : S_IDLE;
                    n_pend  = 1'b0;
                    n_hpass = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.is_tick || !i_st.src_ok) begin
                        o_cmd.emit_zero = 1'b1;
                    end else if (i_st.win_exp) begin
                        o_cmd.win_clr = 1'b1;
                        n_pend  = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        n_hpass = 1'b0;
                        n_state = S_HMUL;
                    end
                end
            end
            S_HMUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_HLD;
            end
            S_HLD: begin
                o_cmd.hld = 1'b1;
                n_state = S_HMOD;
            end
            S_HMOD: begin
                o_cmd.hstep = 1'b1;
                if (i_st.mod_last) begin
                    if (r_hpass) begin
                        n_op    = OP_PKT_ADD;
                        n_state = S_PST;
                    end else begin
                        n_hpass = 1'b1;
                        n_state = S_HMUL;
                    end
                end
            end
            S_PST: begin
                o_cmd.prb_start = 1'b1;
                n_state = S_PRD;
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                o_cmd.prb_chk = 1'b1;
                if (!i_st.resolve) begin
                    n_state = S_PRD;
                end else begin
                    n_state = S_PST;
                    case (r_op)
                        OP_PKT_ADD: n_op = i_st.syn_step ? OP_SYN_ADD : OP_SYN_GET;
                        OP_SYN_ADD: n_op = i_st.res_syn_hit ? OP_PORT_GET : OP_PAIR;
                        OP_SYN_GET: n_op = OP_PAIR;
                        OP_PAIR:    n_op = i_st.slot_free ? OP_PORT_ADD : OP_PORT_GET;
                        default:    n_state = S_EMIT;
                    endcase
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- hdl/sfpsd_dp.sv -----
// ----------------------------------------------------------------------------
// sfpsd_dp
// Datapath: config registers, hash unit, table RAMs, probe logic, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module sfpsd_dp import sfpsd_pkg::*; #(
    parameter int SRC_DEPTH   = 512,
    parameter int PAIR_DEPTH  = 2048,
    parameter int PROBE_LIMIT = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_command,
    input  wire logic        i_source_valid,
    input  wire logic [31:0] i_source_ip,
    input  wire logic [15:0] i_dest_port,
    input  wire logic        i_is_tcp,
    input  wire logic        i_is_syn,
    input  wire logic        i_cfg_wr,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_cmd        i_cmd,
    output t_stat            o_st,
    output logic             o_valid,
    output logic [1:0]       o_threat,
    output logic             o_syn_flood_now,
    output logic             o_port_scan_now,
    output logic             o_ip_flood_now,
    output logic             o_table_full
);

    localparam int SRC_AW  = $clog2(SRC_DEPTH);
    localparam int PAIR_AW = $clog2(PAIR_DEPTH);
    localparam int MAXD    = (SRC_DEPTH > PAIR_DEPTH) ? SRC_DEPTH : PAIR_DEPTH;
    localparam int SW_W    = $clog2(MAXD);
    localparam int RW      = SW_W + 1;
    localparam int TRY_W   = $clog2(PROBE_LIMIT + 1);
    localparam int SRC_EW  = 1 + 32 + COUNT_WIDTH;
    localparam int PAIR_EW = 1 + 48;
    localparam int CMPW    = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [RW-1:0]    SRC_D     = RW'(SRC_DEPTH);
    localparam logic [RW-1:0]    PAIR_D    = RW'(PAIR_DEPTH);
    localparam logic [31:0]      SRC_D32   = 32'(SRC_DEPTH);
    localparam logic [31:0]      PAIR_D32  = 32'(PAIR_DEPTH);
    localparam logic [31:0]      SRC_RECIP  = 32'(64'h1_0000_0000 / 64'(SRC_DEPTH));
    localparam logic [31:0]      PAIR_RECIP = 32'(64'h1_0000_0000 / 64'(PAIR_DEPTH));
    localparam logic [1:0]       MOD_LAST  = 2'd2;
    localparam logic [SW_W:0]    SRC_LIM   = (SW_W+1)'(SRC_DEPTH);
    localparam logic [SW_W:0]    PAIR_LIM  = (SW_W+1)'(PAIR_DEPTH);
    localparam logic [SW_W-1:0]  SW_LAST   = SW_W'(MAXD - 1);
    localparam logic [TRY_W-1:0] TRY_LAST  = TRY_W'(PROBE_LIMIT - 1);
    localparam logic [SRC_AW-1:0]  SRC_TOP  = SRC_AW'(SRC_DEPTH - 1);
    localparam logic [PAIR_AW-1:0] PAIR_TOP = PAIR_AW'(PAIR_DEPTH - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // configuration
    logic [15:0] r_syn_thr, r_scan_thr, r_flood_thr, r_window, r_elapsed;

    // captured packet
    logic [31:0] r_ip;
    logic [15:0] r_port;
    logic        r_syn_step;

    // hash unit
    logic [31:0]     r_prod, r_h, r_q;
    logic [RW-1:0]   r_rem;
    logic [1:0]      r_mcnt;
    logic [31:0]     fold, dep32, recip;
    logic [63:0]     qprod;
    logic [RW-1:0]   mod_d, mod_n;

    // probe
    logic [SW_W-1:0]    r_sweep;
    logic [SRC_AW-1:0]  r_src_base, r_src_slot;
    logic [PAIR_AW-1:0] r_pair_base, r_pair_slot;
    logic [TRY_W-1:0]   r_try;
    logic [COUNT_WIDTH-1:0] r_cnt_pkt, r_cnt_syn, r_cnt_port;
    logic               r_full, r_pair_new;

    // RAM ports
    logic [SRC_EW-1:0]  q_pkt, q_syn, q_port, q_src, src_wdata;
    logic [PAIR_EW-1:0] q_pair, pair_wdata;
    logic [SRC_AW-1:0]  src_addr;
    logic [PAIR_AW-1:0] pair_addr;
    logic               src_clr, pair_clr;
    logic               we_pkt, we_syn, we_port, we_pair;

    logic is_pair, is_add, hit_valid, hit_match, last_try, resolve, do_write;
    logic [COUNT_WIDTH-1:0] src_cnt, res_cnt;
    logic syn_now, scan_now, flood_now;

    // ---------------- configuration and window ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_syn_thr   <= SYN_THR_RST;
            r_scan_thr  <= SCAN_THR_RST;
            r_flood_thr <= FLOOD_THR_RST;
            r_window    <= WINDOW_RST;
            r_elapsed   <= '0;
        end else begin
            if (i_cfg_wr) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SYN_THR:   r_syn_thr   <= i_cfg_data;
                    CFG_SCAN_THR:  r_scan_thr  <= i_cfg_data;
                    CFG_FLOOD_THR: r_flood_thr <= i_cfg_data;
                    CFG_WINDOW:    r_window    <= i_cfg_data;
                    default:       r_window    <= r_window;
                endcase
            end
            if (i_cmd.win_clr) begin
                r_elapsed <= '0;
            end else if (i_cmd.accept && i_command && r_elapsed != ELAPSED_MAX) begin
                r_elapsed <= r_elapsed + 16'd1;
            end
        end
    end

    // ---------------- hash: fold, multiply, mix, reciprocal modulo ----------------
    assign fold  = i_cmd.hpair ? ({r_ip[15:0], r_port} ^ {16'd0, r_ip[31:16]}) : r_ip;
    assign mod_d = i_cmd.hpair ? PAIR_D : SRC_D;
    assign dep32 = i_cmd.hpair ? PAIR_D32 : SRC_D32;
    assign recip = i_cmd.hpair ? PAIR_RECIP : SRC_RECIP;
    // quotient estimate is exact or one low, so the remainder needs one correction
    assign qprod = {32'd0, r_h} * {32'd0, recip};
    assign mod_n = (r_rem >= mod_d) ? (r_rem - mod_d) : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ip       <= i_source_ip;
            r_port     <= i_dest_port;
            r_syn_step <= i_is_tcp & i_is_syn;
        end
        if (i_cmd.mul) begin
            r_prod <= fold * HASH_MULT;
        end
        if (i_cmd.hld) begin
            r_h    <= r_prod ^ {16'd0, r_prod[31:16]};
            r_mcnt <= '0;
        end else if (i_cmd.hstep) begin
            r_mcnt <= r_mcnt + 2'd1;
            case (r_mcnt)
                2'd0: r_q   <= qprod[63:32];
                2'd1: r_rem <= RW'(r_h - r_q * dep32);
                default: begin
                    if (i_cmd.hpair) begin
                        r_pair_base <= mod_n[PAIR_AW-1:0];
                    end else begin
                        r_src_base  <= mod_n[SRC_AW-1:0];
                    end
                end
            endcase
        end
    end

    // ---------------- probe ----------------
    always_comb begin
        case (i_cmd.op)
            OP_PKT_ADD: q_src = q_pkt;
            OP_SYN_ADD: q_src = q_syn;
            OP_SYN_GET: q_src = q_syn;
            default:    q_src = q_port;
        endcase
    end

    assign is_pair   = (i_cmd.op == OP_PAIR);
    assign is_add    = (i_cmd.op == OP_PKT_ADD) || (i_cmd.op == OP_SYN_ADD) ||
                       (i_cmd.op == OP_PORT_ADD);
    assign src_cnt   = q_src[COUNT_WIDTH-1:0];
    assign hit_valid = is_pair ? q_pair[PAIR_EW-1] : q_src[SRC_EW-1];
    assign hit_match = is_pair ? (q_pair[47:0] == {r_ip, r_port})
                               : (q_src[SRC_EW-2 -: 32] == r_ip);
    assign last_try  = (r_try == TRY_LAST);
    assign resolve   = !hit_valid || hit_match || last_try;

    always_comb begin
        res_cnt = '0;
        if (!hit_valid) begin
            res_cnt = is_add ? CNT_ONE : '0;
        end else if (hit_match) begin
            if (is_add && src_cnt != '1) begin
                res_cnt = src_cnt + CNT_ONE;
            end else begin
                res_cnt = src_cnt;
            end
        end
    end

    assign do_write   = i_cmd.prb_chk && (is_add || is_pair) &&
                        (!hit_valid || (hit_match && is_add));
    assign src_wdata  = i_cmd.sweep ? '0 : {1'b1, r_ip, res_cnt};
    assign pair_wdata = i_cmd.sweep ? '0 : {1'b1, r_ip, r_port};
    assign src_addr   = i_cmd.sweep ? r_sweep[SRC_AW-1:0] : r_src_slot;
    assign pair_addr  = i_cmd.sweep ? r_sweep[PAIR_AW-1:0] : r_pair_slot;
    assign src_clr    = i_cmd.sweep && ({1'b0, r_sweep} < SRC_LIM);
    assign pair_clr   = i_cmd.sweep && ({1'b0, r_sweep} < PAIR_LIM);
    assign we_pkt     = src_clr || (do_write && i_cmd.op == OP_PKT_ADD);
    assign we_syn     = src_clr || (do_write && i_cmd.op == OP_SYN_ADD);
    assign we_port    = src_clr || (do_write && i_cmd.op == OP_PORT_ADD);
    assign we_pair    = pair_clr || (do_write && is_pair);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep <= (r_sweep == SW_LAST) ? '0 : r_sweep + SW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_full     <= 1'b0;
            r_pair_new <= 1'b0;
        end
        if (i_cmd.prb_start) begin
            r_src_slot  <= r_src_base;
            r_pair_slot <= r_pair_base;
            r_try       <= '0;
        end else if (i_cmd.prb_chk) begin
            if (!resolve) begin
                // advance to the next slot, wrapping at the table end
                r_try <= r_try + TRY_W'(1);
                if (is_pair) begin
                    r_pair_slot <= (r_pair_slot == PAIR_TOP) ? '0 : r_pair_slot + PAIR_AW'(1);
                end else begin
                    r_src_slot  <= (r_src_slot == SRC_TOP) ? '0 : r_src_slot + SRC_AW'(1);
                end
            end else begin
                if (hit_valid && !hit_match && (is_add || is_pair)) begin
                    r_full <= 1'b1;
                end
                case (i_cmd.op)
                    OP_PKT_ADD:  r_cnt_pkt  <= res_cnt;
                    OP_SYN_ADD:  r_cnt_syn  <= res_cnt;
                    OP_SYN_GET:  r_cnt_syn  <= res_cnt;
                    OP_PAIR:     r_pair_new <= !hit_valid;
                    default:     r_cnt_port <= res_cnt;
                endcase
            end
        end
    end

    sfpsd_ram #(.WIDTH(SRC_EW), .DEPTH(SRC_DEPTH)) u_pkt_ram (
        .i_clk(i_clk), .i_we(we_pkt), .i_addr(src_addr), .i_wdata(src_wdata), .o_rdata(q_pkt)
    );
    sfpsd_ram #(.WIDTH(SRC_EW), .DEPTH(SRC_DEPTH)) u_syn_ram (
        .i_clk(i_clk), .i_we(we_syn), .i_addr(src_addr), .i_wdata(src_wdata), .o_rdata(q_syn)
    );
    sfpsd_ram #(.WIDTH(SRC_EW), .DEPTH(SRC_DEPTH)) u_port_ram (
        .i_clk(i_clk), .i_we(we_port), .i_addr(src_addr), .i_wdata(src_wdata), .o_rdata(q_port)
    );
    sfpsd_ram #(.WIDTH(PAIR_EW), .DEPTH(PAIR_DEPTH)) u_pair_ram (
        .i_clk(i_clk), .i_we(we_pair), .i_addr(pair_addr), .i_wdata(pair_wdata),
        .o_rdata(q_pair)
    );

    // ---------------- status and result ----------------
    assign syn_now   = CMPW'(r_cnt_syn)  > CMPW'(r_syn_thr);
    assign scan_now  = CMPW'(r_cnt_port) > CMPW'(r_scan_thr);
    assign flood_now = CMPW'(r_cnt_pkt)  > CMPW'(r_flood_thr);

    always_comb begin
        o_st.is_tick     = i_command;
        o_st.src_ok      = i_source_valid;
        o_st.win_exp     = (r_elapsed >= r_window);
        o_st.sweep_last  = (r_sweep == SW_LAST);
        o_st.mod_last    = (r_mcnt == MOD_LAST);
        o_st.resolve     = resolve;
        o_st.slot_free   = !hit_valid;
        o_st.syn_step    = r_syn_step;
        o_st.res_syn_hit = CMPW'(res_cnt) > CMPW'(r_syn_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit || i_cmd.emit_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_zero) begin
            o_threat        <= THREAT_NONE;
            o_syn_flood_now <= 1'b0;
            o_port_scan_now <= 1'b0;
            o_ip_flood_now  <= 1'b0;
            o_table_full    <= 1'b0;
        end else if (i_cmd.emit) begin
            if (r_syn_step && syn_now) begin
                o_threat <= THREAT_SYN;
            end else if (r_pair_new && scan_now) begin
                o_threat <= THREAT_SCAN;
            end else begin
                o_threat <= THREAT_NONE;
            end
            o_syn_flood_now <= syn_now;
            o_port_scan_now <= scan_now;
            o_ip_flood_now  <= flood_now;
            o_table_full    <= r_full;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/syn_flood_port_scan_detector.sv -----
// A tick or an invalid-source packet gives its result in the cycle after start.
// A valid packet takes 2 hash passes (multiply, load, modulo), 3 or 4 table ops, each probing
// 1..PROBE_LIMIT slots, and an emit step.
// Window expiry adds a clear sweep over max(SOURCE_TABLE_DEPTH, PAIR_TABLE_DEPTH) addresses.
// Reset: synchronous, active low; afterwards busy stays high for the same sweep.
// One word in flight; busy drops as the o_valid strobe rises, and the receiver cannot stall.
// ----------------------------------------------------------------------------
// syn_flood_port_scan_detector
// Windowed per-source SYN flood and port scan detection over hashed tables.
// ----------------------------------------------------------------------------
`default_nettype none

module syn_flood_port_scan_detector import sfpsd_pkg::*; #(
    parameter int SOURCE_TABLE_DEPTH = 512,
    parameter int PAIR_TABLE_DEPTH   = 2048,
    parameter int PROBE_LIMIT        = 8,
    parameter int COUNT_WIDTH        = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic        i_source_valid,
    input  wire logic [31:0] i_source_ip,
    input  wire logic [15:0] i_dest_port,
    input  wire logic        i_is_tcp,
    input  wire logic        i_is_syn,
    output logic             o_valid,
    output logic [1:0]       o_threat,
    output logic             o_syn_flood_now,
    output logic             o_port_scan_now,
    output logic             o_ip_flood_now,
    output logic             o_table_full,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat st;

    // hold config writes off while a word is in flight
    assign o_cfg_ready = !busy;

    sfpsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    sfpsd_dp #(
        .SRC_DEPTH   (SOURCE_TABLE_DEPTH),
        .PAIR_DEPTH  (PAIR_TABLE_DEPTH),
        .PROBE_LIMIT (PROBE_LIMIT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_command),
        .i_source_valid  (i_source_valid),
        .i_source_ip     (i_source_ip),
        .i_dest_port     (i_dest_port),
        .i_is_tcp        (i_is_tcp),
        .i_is_syn        (i_is_syn),
        .i_cfg_wr        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_st            (st),
        .o_valid         (o_valid),
        .o_threat        (o_threat),
        .o_syn_flood_now (o_syn_flood_now),
        .o_port_scan_now (o_port_scan_now),
        .o_ip_flood_now  (o_ip_flood_now),
        .o_table_full    (o_table_full)
    );

    // tables are swept after reset before any word is taken
    a_reset_sweep: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command) |=> (o_valid && o_threat == THREAT_NONE))
        else $error("tick word gave no empty result");

    a_threat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_threat == THREAT_SYN) |-> o_syn_flood_now)
        else $error("SYN threat without SYN flood flag");

    a_scan_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_threat == THREAT_SCAN) |-> o_port_scan_now)
        else $error("scan threat without port scan flag");

endmodule

`default_nettype wire

// ----- bench/sfpsd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfpsd_checker
// Watches the command, configuration and result ports of the detector, keeps
// its own copy of the hashed source and pair tables, predicts each result word
// and compares it field by field. Reports the mismatch and pending counts.
// ----------------------------------------------------------------------------
module sfpsd_checker import sfpsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_command,
    input  logic        i_source_valid,
    input  logic [31:0] i_source_ip,
    input  logic [15:0] i_dest_port,
    input  logic        i_is_tcp,
    input  logic        i_is_syn,
    input  logic        o_valid,
    input  logic [1:0]  o_threat,
    input  logic        o_syn_flood_now,
    input  logic        o_port_scan_now,
    input  logic        o_ip_flood_now,
    input  logic        o_table_full,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int SRC_DEPTH  = 512;
    localparam int PAIR_DEPTH = 2048;
    localparam int PROBES     = 8;
    localparam int TBL_PKT    = 0;
    localparam int TBL_SYN    = 1;
    localparam int TBL_PORT   = 2;

    typedef struct packed {
        t_threat threat;
        logic    syn_hi;
        logic    scan_hi;
        logic    ip_flood;
        logic    full;
    } t_verdict;

    t_verdict    verdicts_q[$];

    logic        src_used[3][SRC_DEPTH];
    logic [31:0] src_key[3][SRC_DEPTH];
    logic [15:0] src_cnt[3][SRC_DEPTH];
    logic        pair_used[PAIR_DEPTH];
    logic [47:0] pair_key[PAIR_DEPTH];

    logic [15:0] syn_thr, scan_thr, flood_thr, window_len, elapsed;

    function automatic int unsigned bucket(logic [63:0] key, int unsigned depth);
        logic [31:0] h;
        h = key[31:0] ^ key[63:32];
        h = h * HASH_MULT;
        h = h ^ (h >> 16);
        return h % depth;
    endfunction

    // slot of match or first free slot, -1 when the probe window is full
    function automatic int find_src(int t, logic [31:0] ip, output bit hit);
        int unsigned base;
        int s;
        base = bucket({32'd0, ip}, SRC_DEPTH);
        hit = 0;
        for (int i = 0; i < PROBES; i++) begin
            s = (base + i) % SRC_DEPTH;
            if (!src_used[t][s]) return s;
            if (src_key[t][s] == ip) begin
                hit = 1;
                return s;
            end
        end
        return -1;
    endfunction

    function automatic int find_pair(logic [47:0] key, output bit hit);
        int unsigned base;
        int s;
        base = bucket({16'd0, key}, PAIR_DEPTH);
        hit = 0;
        for (int i = 0; i < PROBES; i++) begin
            s = (base + i) % PAIR_DEPTH;
            if (!pair_used[s]) return s;
            if (pair_key[s] == key) begin
                hit = 1;
                return s;
            end
        end
        return -1;
    endfunction

    function automatic void bump(int t, logic [31:0] ip, inout logic full);
        bit hit;
        int s;
        s = find_src(t, ip, hit);
        if (hit) begin
            if (src_cnt[t][s] != 16'hFFFF) src_cnt[t][s]++;
        end else if (s >= 0) begin
            src_used[t][s] = 1;
            src_key[t][s]  = ip;
            src_cnt[t][s]  = 16'd1;
        end else begin
            full = 1;
        end
    endfunction

    function automatic logic [15:0] count_of(int t, logic [31:0] ip);
        bit hit;
        int s;
        s = find_src(t, ip, hit);
        return hit ? src_cnt[t][s] : 16'd0;
    endfunction

    function automatic void clear_tables();
        for (int t = 0; t < 3; t++)
            for (int i = 0; i < SRC_DEPTH; i++) src_used[t][i] = 0;
        for (int i = 0; i < PAIR_DEPTH; i++) pair_used[i] = 0;
    endfunction

    function automatic void predict_packet();
        t_verdict v;
        logic [47:0] pair;
        bit hit;
        int s;
        v = '0;
        v.threat = THREAT_NONE;
        if (i_command) begin
            if (elapsed != ELAPSED_MAX) elapsed++;
        end else if (i_source_valid) begin
            if (elapsed >= window_len) begin
                clear_tables();
                elapsed = '0;
            end
            bump(TBL_PKT, i_source_ip, v.full);
            if (i_is_tcp && i_is_syn) begin
                bump(TBL_SYN, i_source_ip, v.full);
                if (count_of(TBL_SYN, i_source_ip) > syn_thr) v.threat = THREAT_SYN;
            end
            if (v.threat == THREAT_NONE) begin
                pair = {i_source_ip, i_dest_port};
                s = find_pair(pair, hit);
                if (!hit) begin
                    if (s >= 0) begin
                        pair_used[s] = 1;
                        pair_key[s]  = pair;
                        bump(TBL_PORT, i_source_ip, v.full);
                        if (count_of(TBL_PORT, i_source_ip) > scan_thr)
                            v.threat = THREAT_SCAN;
                    end else begin
                        v.full = 1;
                    end
                end
            end
            v.syn_hi   = count_of(TBL_SYN, i_source_ip) > syn_thr;
            v.scan_hi  = count_of(TBL_PORT, i_source_ip) > scan_thr;
            v.ip_flood = count_of(TBL_PKT, i_source_ip) > flood_thr;
        end
        verdicts_q.push_back(v);
    endfunction

    task automatic check_word();
        t_verdict v;
        if (verdicts_q.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            o_errors++;
            return;
        end
        v = verdicts_q.pop_front();
        if (o_threat != v.threat) begin
            $display("%0t: threat exp %0d got %0d", $time, v.threat, o_threat);
            o_errors++;
        end
        if (o_syn_flood_now != v.syn_hi) begin
            $display("%0t: syn_flood_now exp %0b got %0b", $time, v.syn_hi, o_syn_flood_now);
            o_errors++;
        end
        if (o_port_scan_now != v.scan_hi) begin
            $display("%0t: port_scan_now exp %0b got %0b", $time, v.scan_hi, o_port_scan_now);
            o_errors++;
        end
        if (o_ip_flood_now != v.ip_flood) begin
            $display("%0t: ip_flood_now exp %0b got %0b", $time, v.ip_flood, o_ip_flood_now);
            o_errors++;
        end
        if (o_table_full != v.full) begin
            $display("%0t: table_full exp %0b got %0b", $time, v.full, o_table_full);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tables();
            verdicts_q.delete();
            elapsed    = '0;
            syn_thr    = SYN_THR_RST;
            scan_thr   = SCAN_THR_RST;
            flood_thr  = FLOOD_THR_RST;
            window_len = WINDOW_RST;
        end else begin
            if (o_valid) check_word();
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SYN_THR:   syn_thr    = i_cfg_data;
                    CFG_SCAN_THR:  scan_thr   = i_cfg_data;
                    CFG_FLOOD_THR: flood_thr  = i_cfg_data;
                    CFG_WINDOW:    window_len = i_cfg_data;
                    default:       window_len = window_len;
                endcase
            end
            if (start && !busy) predict_packet();
        end
        o_pending = verdicts_q.size();
    end

endmodule

// ----- bench/tb_syn_flood_port_scan_detector.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_syn_flood_port_scan_detector
// Drives directed and random packet and tick words, with threshold and window
// changes between phases, into the detector; the checker scores the results.
// ----------------------------------------------------------------------------
module tb_syn_flood_port_scan_detector;
    import sfpsd_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_command = 0;
    logic        i_source_valid = 0;
    logic [31:0] i_source_ip = '0;
    logic [15:0] i_dest_port = '0;
    logic        i_is_tcp = 0;
    logic        i_is_syn = 0;
    logic        o_valid;
    logic [1:0]  o_threat;
    logic        o_syn_flood_now, o_port_scan_now, o_ip_flood_now, o_table_full;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    int          errors, pending, cycles = 0;
    bit          idling = 1;
    logic [31:0] hosts[6];

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    syn_flood_port_scan_detector i_dut (.*);

    sfpsd_checker i_checker (.*, .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_syn_flood_port_scan_detector NOT OK");
            $finish;
        end
    end

    // bucket of a key, used to build colliding sources and pairs
    function automatic int unsigned hash_slot(logic [63:0] key, int unsigned depth);
        logic [31:0] h;
        h = key[31:0] ^ key[63:32];
        h = h * HASH_MULT;
        h = h ^ (h >> 16);
        return h % depth;
    endfunction

    task automatic send(logic cmd, logic ok, logic [31:0] ip, logic [15:0] port,
                        logic tcp, logic syn);
        @(negedge i_clk);
        if (idling && $urandom_range(3) == 0) begin
            start = 0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        start = 1;
        i_command = cmd;
        i_source_valid = ok;
        i_source_ip = ip;
        i_dest_port = port;
        i_is_tcp = tcp;
        i_is_syn = syn;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [15:0] data);
        drain();
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = data;
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function automatic logic [15:0] pick_thr();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(8, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_word();
        logic [31:0] ip;
        logic [15:0] port;
        int r;
        r = $urandom_range(99);
        ip = ($urandom_range(4) != 0) ? hosts[$urandom_range(5)] : $urandom;
        port = ($urandom_range(9) < 7) ? 16'($urandom_range(40)) : 16'($urandom);
        if (r < 5)
            send(1'b1, 1'($urandom), $urandom, 16'($urandom), 1'($urandom), 1'($urandom));
        else if (r < 10)
            send(1'b0, 1'b0, $urandom, 16'($urandom), 1'($urandom), 1'($urandom));
        else
            send(0, 1, ip, port, $urandom_range(3) != 0, $urandom_range(2) != 0);
    endtask

    initial begin
        logic [31:0] ip;
        int unsigned slot;
        int n;

        foreach (hosts[i]) hosts[i] = $urandom;
        hosts[0] = 32'h0;
        hosts[1] = 32'hFFFF_FFFF;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;

        // directed: ticks, ignored packets, field extremes at reset settings
        send(1, 1, 32'hFFFF_FFFF, 16'hFFFF, 1, 1);
        send(0, 0, 32'hFFFF_FFFF, 16'hFFFF, 1, 1);
        send(0, 1, 32'h0, 16'h0, 0, 0);
        send(0, 1, 32'hFFFF_FFFF, 16'hFFFF, 1, 1);
        send(0, 1, 32'hFFFF_FFFF, 16'hFFFF, 1, 0);
        send(0, 1, 32'hFFFF_FFFF, 16'hFFFF, 0, 1);

        // tiny thresholds: flood, scan and a repeated pair
        set_reg(CFG_SYN_THR, 16'd0);
        set_reg(CFG_SCAN_THR, 16'd0);
        set_reg(CFG_FLOOD_THR, 16'd0);
        set_reg(CFG_WINDOW, 16'hFFFF);
        send(0, 1, 32'h0A00_0001, 16'd80, 1, 1);
        send(0, 1, 32'h0A00_0001, 16'd22, 0, 0);
        send(0, 1, 32'h0A00_0001, 16'd22, 1, 0);

        // sources colliding in one bucket overflow the probe window
        slot = hash_slot({32'd0, 32'h0A00_0002}, 512);
        n = 0;
        while (n < 10) begin
            ip = $urandom;
            if (hash_slot({32'd0, ip}, 512) == slot) begin
                send(0, 1, ip, 16'd1, 1, 1);
                n++;
            end
        end
        // pairs of one source colliding in the pair set
        slot = hash_slot({16'd0, 32'h0B00_0003, 16'd0}, 2048);
        for (int p = 1; p < 65536 && n < 20; p++)
            if (hash_slot({16'd0, 32'h0B00_0003, 16'(p)}, 2048) == slot) begin
                send(0, 1, 32'h0B00_0003, 16'(p), 0, 0);
                n++;
            end

        // window expiry at a window of one tick
        set_reg(CFG_WINDOW, 16'd1);
        send(1, 0, 0, 0, 0, 0);
        send(0, 1, 32'h0A00_0001, 16'd80, 1, 1);

        // random phases with fresh settings each time
        for (int ph = 0; ph < 6; ph++) begin
            set_reg(CFG_SYN_THR, pick_thr());
            set_reg(CFG_SCAN_THR, pick_thr());
            set_reg(CFG_FLOOD_THR, pick_thr());
            case (ph % 3)
                0: set_reg(CFG_WINDOW, 16'd1);
                1: set_reg(CFG_WINDOW, 16'hFFFF);
                default: set_reg(CFG_WINDOW, 16'($urandom_range(12, 2)));
            endcase
            idling = (ph != 5);
            repeat (230) random_word();
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (errors == 0)
            $display("tb_syn_flood_port_scan_detector OK");
        else
            $display("tb_syn_flood_port_scan_detector NOT OK");
        $finish;
    end

endmodule
